// ===== rtl/asc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants of the ADC setpoint conditioner
// Holds the fixed field widths, register indexes, reset values, the
// configuration record and the state encoding of the back-end sequencer.
// ----------------------------------------------------------------------------
package asc_pkg;

	// Fixed field widths.
	localparam int SMP_W   = 12;   // raw converter reading
	localparam int SPD_W   = 27;   // Q11.16 RPM setpoint
	localparam int GAIN_W  = 16;   // Q0.16 filter gain

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP   = 2'd3;

	// Register reset values.
	localparam logic [SPD_W-1:0]  RST_SPEED_MIN   = 27'd3276800;
	localparam logic [SPD_W-1:0]  RST_SPEED_MAX   = 27'd42598400;
	localparam logic [GAIN_W-1:0] RST_FILTER_GAIN = 16'd3277;
	localparam logic [SPD_W-1:0]  RST_SLEW_STEP   = 27'd655360;

	// Configuration record handed to the back end.
	typedef struct packed {
		logic [SPD_W-1:0]  speed_min;
		logic [SPD_W-1:0]  speed_max;
		logic [GAIN_W-1:0] filter_gain;
		logic [SPD_W-1:0]  slew_step;
	} cfg_t;

	// Back-end sequencer states.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_AVG  = 7'b0000010,
		ST_MUL1 = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_MUL2 = 7'b0010000,
		ST_FILT = 7'b0100000,
		ST_SLEW = 7'b1000000
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/asc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asc_front: sample accumulator
// Accepts raw readings, sums each oversample group and pushes the finished
// group sum into the queue toward the back end.
// ----------------------------------------------------------------------------
module asc_front import asc_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int OVERSAMPLE  = 16,
	parameter int SUM_W       = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [SMP_W-1:0] adc_sample,
	output logic                  push,
	output logic [SUM_W-1:0]      push_data,
	input  wire logic             q_full
);

	localparam int CNT_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
	localparam int EXT_W = (SAMPLE_BITS > SMP_W) ? SAMPLE_BITS : SMP_W;
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(OVERSAMPLE - 1);

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [EXT_W-1:0] sample_ext;
	logic [SUM_W-1:0] sum_next;
	logic             last;
	logic             accept;

	// Only the low SAMPLE_BITS of the reading take part.
	assign sample_ext = EXT_W'(adc_sample);
	assign sum_next   = sum_q + SUM_W'(sample_ext[SAMPLE_BITS-1:0]);

	// The closing beat of a group waits for room in the queue.
	assign last      = (cnt_q == LAST_CNT);
	assign in_stall  = last && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = accept && last;
	assign push_data = sum_next;

	// Group sum and sample count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/asc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asc_queue: two-entry queue of group sums
// Decouples the accumulator from the arithmetic sequencer.
// ----------------------------------------------------------------------------
module asc_queue import asc_pkg::*; #(
	parameter int WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign data  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/asc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asc_div: divider by 2^SB - 1
// Folds the dividend one step per cycle: with x = h * 2^SB + l the quotient
// grows by h and x becomes h + l. Once the high part is zero, an all-ones
// low part adds one more to the quotient. A 39-bit dividend needs at most
// four folding steps.
// ----------------------------------------------------------------------------
module asc_div import asc_pkg::*; #(
	parameter int SB  = 12,
	parameter int Q_W = 27
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SB+Q_W-1:0]  dividend,
	output logic                    done,
	output logic [Q_W-1:0]          quot
);

	localparam int DVD_W = SB + Q_W;

	logic [DVD_W-1:0] fold_q;
	logic [Q_W-1:0]   acc_q;
	logic             busy_q;
	logic             done_q;
	logic [Q_W-1:0]   fold_hi;
	logic [SB-1:0]    fold_lo;
	logic             hi_zero;
	logic             lo_full;

	// Split of the running value into its high and low parts.
	assign fold_hi = fold_q[DVD_W-1:SB];
	assign fold_lo = fold_q[SB-1:0];
	assign hi_zero = (fold_hi == '0);
	assign lo_full = &fold_lo;
	assign done    = done_q;
	assign quot    = acc_q;

	// Running value and quotient accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			fold_q <= dividend;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (!hi_zero) begin
				acc_q  <= acc_q + fold_hi;
				fold_q <= DVD_W'(fold_hi) + DVD_W'(fold_lo);
			end else begin
				acc_q <= acc_q + Q_W'(lo_full);
			end
		end
	end

	// Busy flag and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (hi_zero) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/asc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asc_back: arithmetic sequencer
// Averages one group sum, maps it onto the speed range, clamps, filters and
// slew-limits it, and holds the new setpoint in the output register. The
// average is a product with a constant reciprocal, one multiplier is shared
// by the mapping and the filter, and a folding divider yields the mapping
// quotient.
// ----------------------------------------------------------------------------
module asc_back import asc_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int OVERSAMPLE  = 16,
	parameter int SUM_W       = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             q_valid,
	input  wire logic [SUM_W-1:0] q_data,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [SPD_W-1:0]      setpoint
);

	localparam int SB    = SAMPLE_BITS;
	localparam int DVD_W = SB + SPD_W;
	localparam int MA_W  = SPD_W + 2;
	localparam int MB_W  = GAIN_W + 1;
	localparam int MP_W  = MA_W + MB_W;
	localparam int NF_W  = SPD_W + 3;
	// floor(sum / OVERSAMPLE) = (sum * ceil(2^RC_SH / OVERSAMPLE)) >> RC_SH
	localparam int OS_L  = $clog2(OVERSAMPLE);
	localparam int RC_SH = SUM_W + OS_L;
	localparam int RP_W  = 2 * SUM_W + 1;
	localparam longint RC_M = ((64'sd1 <<< RC_SH) + longint'(OVERSAMPLE) - 1) /
		longint'(OVERSAMPLE);
	localparam logic [RP_W-1:0] RC_MUL = RP_W'(RC_M);

	back_state_t state_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SB-1:0]          avg_q;
	logic [SPD_W-1:0]       mapped_q;
	logic signed [MP_W-1:0] prod_q;
	logic signed [NF_W-1:0] nf_q;
	logic [SPD_W-1:0]       f_q;
	logic [SPD_W-1:0]       out_q;
	logic                   out_valid_q;

	// Average by reciprocal product.
	logic [RP_W-1:0]        avg_prod;

	// Divider request.
	logic                   div_start;
	logic [DVD_W-1:0]       div_dvd;
	logic                   div_done;
	logic [SPD_W-1:0]       div_quot;

	// Shared multiplier.
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_p;

	logic signed [SPD_W:0]  span;
	logic                   span_neg;
	logic [SPD_W-1:0]       span_mag;
	logic signed [MA_W-1:0] lo_s;
	logic signed [MA_W-1:0] hi_s;
	logic signed [MA_W-1:0] quot_s;
	logic signed [MA_W-1:0] map_raw;
	logic signed [MA_W-1:0] map_lo;
	logic signed [MA_W-1:0] map_clamp;
	logic signed [NF_W-1:0] f_s;
	logic signed [NF_W-1:0] step_s;
	logic signed [NF_W-1:0] up_lim;
	logic signed [NF_W-1:0] dn_lim;
	logic signed [NF_W-1:0] slew_res;
	logic                   out_load;

	// Signed span and its magnitude; the sign is put back after the division.
	assign span     = $signed({1'b0, cfg.speed_max}) - $signed({1'b0, cfg.speed_min});
	assign span_neg = span[SPD_W];
	assign span_mag = span_neg ? SPD_W'(-span) : SPD_W'(span);

	// Group average from the captured sum.
	assign avg_prod = RP_W'(sum_q) * RC_MUL;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// The mapping product goes to the divider by full scale.
	assign div_start = (state_q == ST_MUL1);
	assign div_dvd   = mul_p[DVD_W-1:0];

	asc_div #(
		.SB  (SB),
		.Q_W (SPD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Multiplier operands: average times span, then error times gain.
	always_comb begin
		if (state_q == ST_MUL2) begin
			mul_a = $signed({2'b00, mapped_q}) - $signed({2'b00, f_q});
			mul_b = $signed({1'b0, cfg.filter_gain});
		end else begin
			mul_a = $signed({2'b00, span_mag});
			mul_b = $signed({1'b0, GAIN_W'(avg_q)});
		end
	end
	assign mul_p = mul_a * mul_b;

	// Mapping with the span's sign, then clamping to the configured range.
	assign lo_s      = $signed({2'b00, cfg.speed_min});
	assign hi_s      = $signed({2'b00, cfg.speed_max});
	assign quot_s    = $signed({2'b00, div_quot});
	assign map_raw   = span_neg ? (lo_s - quot_s) : (lo_s + quot_s);
	assign map_lo    = (map_raw < lo_s) ? lo_s : map_raw;
	assign map_clamp = (map_lo > hi_s) ? hi_s : map_lo;

	// Slew limits around the previous filter value.
	assign f_s      = $signed({3'b000, f_q});
	assign step_s   = $signed({3'b000, cfg.slew_step});
	assign up_lim   = f_s + step_s;
	assign dn_lim   = f_s - step_s;
	assign slew_res = (nf_q > up_lim) ? up_lim : ((nf_q < dn_lim) ? dn_lim : nf_q);

	assign out_load = (state_q == ST_SLEW) && (!out_valid_q || !out_stall);

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sum_q <= q_data;
		end
		if (state_q == ST_AVG) begin
			avg_q <= avg_prod[RC_SH +: SB];
		end
		if (state_q == ST_DIV && div_done) begin
			mapped_q <= map_clamp[SPD_W-1:0];
		end
		if (state_q == ST_MUL2) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_FILT) begin
			// Arithmetic shift by 16 is the floor of the Q0.16 product.
			nf_q <= f_s + $signed(prod_q[MP_W-1:GAIN_W]);
		end
		if (out_load) begin
			out_q <= slew_res[SPD_W-1:0];
		end
	end

	// Sequencer, filter state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			f_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					state_q <= ST_FILT;
				end
				ST_FILT: begin
					state_q <= ST_SLEW;
				end
				ST_SLEW: begin
					if (out_load) begin
						f_q     <= slew_res[SPD_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign setpoint  = out_q;

endmodule
`default_nettype wire

// ===== rtl/adc_setpoint_conditioner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_setpoint_conditioner: ADC reading to speed setpoint conditioner
// Oversampling average, linear mapping, clamp, IIR filter and slew limit.
// ----------------------------------------------------------------------------
// The block takes one reading per cycle unless in_stall is raised; every
// OVERSAMPLE readings the group sum goes into a two-entry queue and the input
// keeps flowing. For each group the back end takes the sum, averages it by a
// constant reciprocal product, forms the mapping product, divides it by
// 2^SAMPLE_BITS - 1 with a folding divider (at most four folding steps at the
// defaults), and then forms the filter product, the filter sum and the slew
// limit. The back end works on one group at a time, while the queue lets the
// input go on; the input stalls only on a group's closing beat while the
// queue is full, which at the defaults happens only while the output is held
// back. One setpoint beat leaves per group and waits in the output register;
// the next slew step waits until that beat is taken. The filter starts at
// zero, so the first setpoints ramp up from zero. Registers are to be written
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module adc_setpoint_conditioner import asc_pkg::*; #(
	parameter int OVERSAMPLE  = 16,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SPD_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [SMP_W-1:0]     adc_sample,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [SPD_W-1:0]          setpoint
);

	localparam int SUM_W = $clog2(OVERSAMPLE * ((1 << SAMPLE_BITS) - 1) + 1);

	cfg_t             cfg_q;
	logic             push;
	logic [SUM_W-1:0] push_data;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	logic [SUM_W-1:0] q_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_min   <= RST_SPEED_MIN;
			cfg_q.speed_max   <= RST_SPEED_MAX;
			cfg_q.filter_gain <= RST_FILTER_GAIN;
			cfg_q.slew_step   <= RST_SLEW_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_MIN:   cfg_q.speed_min   <= cfg_data;
				REG_SPEED_MAX:   cfg_q.speed_max   <= cfg_data;
				REG_FILTER_GAIN: cfg_q.filter_gain <= cfg_data[GAIN_W-1:0];
				REG_SLEW_STEP:   cfg_q.slew_step   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	asc_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.OVERSAMPLE  (OVERSAMPLE),
		.SUM_W       (SUM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	asc_queue #(
		.WIDTH (SUM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	asc_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.OVERSAMPLE  (OVERSAMPLE),
		.SUM_W       (SUM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.setpoint  (setpoint)
	);

endmodule
`default_nettype wire

// ===== rtl/asc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// asc_checker: port-level checks of the setpoint conditioner
// Watches both handshakes and the per-update slew bound.
// ----------------------------------------------------------------------------
module asc_checker import asc_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [SPD_W-1:0]     cfg_data,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [SMP_W-1:0]     adc_sample,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [SPD_W-1:0]     setpoint
);

	logic [SPD_W-1:0] last_q;
	logic [SPD_W-1:0] step_q;
	logic [SPD_W-1:0] delta;
	logic             out_beat;

	assign out_beat = out_valid && !out_stall;
	assign delta    = (setpoint >= last_q) ? (setpoint - last_q) : (last_q - setpoint);

	// Mirror of the slew register and of the last delivered setpoint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			step_q <= RST_SLEW_STEP;
		end else begin
			if (cfg_we && cfg_index == REG_SLEW_STEP) begin
				step_q <= cfg_data;
			end
			if (out_beat) begin
				last_q <= setpoint;
			end
		end
	end

	// A stalled reading stays offered unchanged by the source.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(adc_sample))
		else $error("stalled reading beat was dropped or changed");

	// A stalled output beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(setpoint))
		else $error("stalled setpoint beat was dropped or changed");

	// Consecutive setpoints never move by more than the slew step.
	a_slew: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> delta <= step_q)
		else $error("setpoint moved by more than the slew step");

	// Out of reset the output is not valid and the input does not stall:
	// a stall cannot appear out of reset.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid && !in_stall)
		else $error("activity right after reset");

	// Two setpoints are at least the sequencer's length apart, so a beat that
	// was taken is followed by a gap with out_valid low unless one was already
	// waiting.
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_beat |=> !out_valid ##1 !out_valid)
		else $error("setpoints delivered closer than the sequencer allows");

endmodule

bind adc_setpoint_conditioner asc_checker u_asc_checker (.*);
`default_nettype wire
